### design/fmprt_pkg.sv
// ----------------------------------------------------------------------------
// fmprt_pkg: shared types for the first-match packet rule table
// Item formats, action codes, rule entry layout and the control interface
// between controller and datapath.
// ----------------------------------------------------------------------------
package fmprt_pkg;

  localparam int unsigned MaxRulesDflt = 16;

  // action codes; code 3 is unused, leaves the table unchanged and gives an empty result
  typedef enum logic [1:0] {
    ActLookup = 2'd0,
    ActAppend = 2'd1,
    ActClear  = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  verdict_value;
  } rule_in_t;

  typedef struct packed {
    logic [7:0] verdict;
    logic       hit;
    logic       status;
  } rule_out_t;

  // one stored rule
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  verdict;
  } rule_t;

  typedef struct packed {
    logic load_item;   // capture accepted item
    logic res_clear;   // start a new result
    logic drop;        // append dropped, flag in status
    logic append;      // write item as new rule
    logic tbl_clear;   // empty the table
    logic scan_start;  // read entry 0
    logic scan_step;   // read next entry
    logic hit;         // capture verdict of compared entry
    logic finish;      // move result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic is_append;
    logic is_clear;
    logic empty;
    logic full;
    logic match;       // compared entry matches the item
    logic last;        // compared entry is the newest rule
    logic out_free;    // output register can take a result
  } dp_status_t;

endpackage

### design/first_match_packet_rule_table.sv
// ----------------------------------------------------------------------------
// first_match_packet_rule_table: five-tuple packet filter, first match wins
// Append, clear and lookup over an insertion-ordered rule table.
// ----------------------------------------------------------------------------
// Append, clear and unused actions go from execute straight to finish; a lookup on a
//   non-empty table first scans the rules oldest first, one per cycle, until a match or the newest rule.
// One item at a time: the next item is taken the cycle after the result moves into the
//   output register.
// Reset: asynchronous, clears the controller, the rule count and output valid.
//   Rule storage is not cleared; entries at or beyond the count are never read.
module first_match_packet_rule_table #(
  parameter int unsigned MAX_RULES = fmprt_pkg::MaxRulesDflt
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fmprt_pkg::rule_in_t  in_data_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fmprt_pkg::rule_out_t out_data_o
);
  import fmprt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: idle -> execute -> scan (lookups) -> hand result off
  fmprt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // rule memory, compare logic and output register
  fmprt_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

### design/fmprt_ctrl.sv
// ----------------------------------------------------------------------------
// fmprt_ctrl: controller for the rule table
// One-hot state machine that sequences execute, scan and result hand-off.
// ----------------------------------------------------------------------------
module fmprt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fmprt_pkg::dp_status_t status_i,
  output fmprt_pkg::dp_cmd_t    cmd_o
);
  import fmprt_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StExec   = 4'b0010,
    StScan   = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = StExec;
        end
      end
      StExec: begin
        cmd_o.res_clear = 1'b1;
        if (status_i.is_lookup && !status_i.empty) begin
          cmd_o.scan_start = 1'b1;
          state_d          = StScan;
        end else begin
          if (status_i.is_append) begin
            cmd_o.drop   = status_i.full;
            cmd_o.append = !status_i.full;
          end
          cmd_o.tbl_clear = status_i.is_clear;
          state_d         = StFinish;
        end
      end
      StScan: begin
        priority if (status_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = StFinish;
        end else if (status_i.last) begin
          state_d = StFinish;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      StFinish: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/fmprt_dp.sv
// ----------------------------------------------------------------------------
// fmprt_dp: datapath for the rule table
// Rule memory, rule count, item register, scan compare and output register.
// ----------------------------------------------------------------------------
module fmprt_dp #(
  parameter int unsigned MAX_RULES = fmprt_pkg::MaxRulesDflt
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fmprt_pkg::rule_in_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fmprt_pkg::rule_out_t  out_data_o,
  input  fmprt_pkg::dp_cmd_t    cmd_i,
  output fmprt_pkg::dp_status_t status_o
);
  import fmprt_pkg::*;

  localparam int unsigned IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CntW = $clog2(MAX_RULES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_RULES);

  rule_in_t             item_q;
  rule_t                mem_q [MAX_RULES];
  rule_t                rd_data_q;
  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic [IdxW-1:0]      cmp_idx_q;
  logic [CntW-1:0]      count_q;
  rule_out_t            res_q;
  rule_out_t            out_q;
  logic                 out_valid_q;
  rule_t                wr_rule;

  // item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
  end

  // rule memory: one write, one registered read per cycle
  assign wr_rule = '{src_ip:   item_q.src_ip,
                     dst_ip:   item_q.dst_ip,
                     protocol: item_q.protocol,
                     src_port: item_q.src_port,
                     dst_port: item_q.dst_port,
                     verdict:  item_q.verdict_value};

  assign rd_en   = cmd_i.scan_start || cmd_i.scan_step;
  assign rd_addr = cmd_i.scan_start ? '0 : IdxW'(cmp_idx_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem_q[count_q[IdxW-1:0]] <= wr_rule;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // index of the entry held in rd_data_q
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cmp_idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.tbl_clear) begin
      count_q <= '0;
    end else if (cmd_i.append) begin
      count_q <= count_q + 1'b1;
    end
  end

  // zero in a rule field is a wildcard
  logic m_sip, m_dip, m_pr, m_sp, m_dp;
  assign m_sip = (rd_data_q.src_ip   == '0) || (rd_data_q.src_ip   == item_q.src_ip);
  assign m_dip = (rd_data_q.dst_ip   == '0) || (rd_data_q.dst_ip   == item_q.dst_ip);
  assign m_pr  = (rd_data_q.protocol == '0) || (rd_data_q.protocol == item_q.protocol);
  assign m_sp  = (rd_data_q.src_port == '0) || (rd_data_q.src_port == item_q.src_port);
  assign m_dp  = (rd_data_q.dst_port == '0) || (rd_data_q.dst_port == item_q.dst_port);

  // result under construction
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_clear) begin
      res_q <= '{verdict: '0, hit: 1'b0, status: cmd_i.drop};
    end else if (cmd_i.hit) begin
      res_q <= '{verdict: rd_data_q.verdict, hit: 1'b1, status: 1'b0};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    status_o           = '0;
    unique case (action_e'(item_q.action))
      ActLookup: status_o.is_lookup = 1'b1;
      ActAppend: status_o.is_append = 1'b1;
      ActClear:  status_o.is_clear  = 1'b1;
      default:   ;
    endcase
    status_o.empty    = (count_q == '0);
    status_o.full     = (count_q == MaxCnt);
    status_o.match    = m_sip && m_dip && m_pr && m_sp && m_dp;
    status_o.last     = ((CntW'(cmp_idx_q) + 1'b1) == count_q);
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

endmodule
